FILE: rtl/rpvg_pkg.sv
// Package for the regular polygon vertex generator: state encoding, register
// indexes, CORDIC arctangent table and fixed-point constants.
// No dependencies.
package rpvg_pkg;

  localparam int MinSides       = 3;
  localparam int MaxSidesDef    = 16;
  localparam int CordicStepsDef = 16;

  // Width of the configuration register index.
  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgSideCount = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgRadius    = CfgIdxW'(1);

  // Full turn is 2^16: the reciprocal division works on 2^16 over the count,
  // one quotient bit per cycle, from bit DivTop down to bit 0.
  localparam int DivTop = 16;

  // CORDIC gain K scaled by 2^30.
  localparam logic [29:0] CordicGain = 30'd652032874;

  // atan(2^-i) as a 32-bit binary angle (2^32 is a full turn).
  localparam int AtanDepth = 24;
  localparam logic [29:0] AtanTab [AtanDepth] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
    30'd42667331,  30'd21354465,  30'd10680862,  30'd5340245,
    30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
    30'd166886,    30'd83443,     30'd41722,     30'd20861,
    30'd10430,     30'd5215,      30'd2608,      30'd1304,
    30'd652,       30'd326,       30'd163,       30'd81
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SETUP,
    ST_ITER,
    ST_EMIT
  } state_e;

endpackage

FILE: rtl/regular_polygon_vertex_generator.sv
// Regular polygon vertex generator: one polygon centre in, count vertices out.
// The angle step is found by division first; then each vertex takes a setup step,
// the rotations on one shared CORDIC rotator and an emit; the emit may stall on
// out_ready_i. A new centre is taken only in idle, after the previous polygon's last vertex.
// Reset (rst_ni low, async): idle, side_count = 3, radius = 0, no output item.
// Depends on rpvg_pkg.
module regular_polygon_vertex_generator #(
  parameter int MAX_SIDES    = rpvg_pkg::MaxSidesDef,
  parameter int CORDIC_STEPS = rpvg_pkg::CordicStepsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration write channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [rpvg_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [15:0]                  cfg_data_i,
  // input items: polygon centre
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [15:0]           center_x_i,
  input  logic signed [15:0]           center_y_i,
  // output items: vertices
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [15:0]           vertex_x_o,
  output logic signed [15:0]           vertex_y_o,
  output logic                         last_vertex_o
);

  // Count width holds MAX_SIDES itself; step width indexes the rotations.
  localparam int CW  = $clog2(MAX_SIDES + 1);
  localparam int STW = $clog2(CORDIC_STEPS);
  localparam int DW  = $clog2(rpvg_pkg::DivTop + 1);
  localparam int AW  = $clog2(rpvg_pkg::AtanDepth);

  rpvg_pkg::state_e state_q, state_d;

  // configuration registers
  logic [7:0]  side_count_q, side_count_d;
  logic [15:0] radius_q, radius_d;

  // radius * K, registered straight after the multiplier
  logic [45:0] gain_prod;
  logic [29:0] gain_q;

  // per-polygon registers
  logic signed [15:0] cx_q, cx_d, cy_q, cy_d;
  logic [CW-1:0]      count_q, count_d;
  logic [CW-1:0]      idx_q, idx_d;
  logic [DW-1:0]      div_cnt_q, div_cnt_d;
  logic [15:0]        quo_q, quo_d;     // floor(2^16 / count)
  logic [CW-1:0]      rinc_q, rinc_d;   // 2^16 mod count
  logic [CW-1:0]      rem_q, rem_d;     // running remainder of the angle
  logic [15:0]        ang_q, ang_d;     // binary angle of the current vertex

  // CORDIC rotator
  logic signed [33:0] x_q, x_d, y_q, y_d, z_q, z_d;
  logic               flip_q, flip_d;
  logic [STW-1:0]     step_q, step_d;

  // output register
  logic               out_valid_q, out_valid_d;
  logic signed [15:0] vx_q, vx_d, vy_q, vy_d;
  logic               last_q, last_d;

  // combinational helpers
  logic [CW:0]        div_shift;
  logic               div_ge;
  logic [CW:0]        rem_acc;
  logic               rem_wrap;
  logic signed [16:0] ang_s;
  logic signed [17:0] ang_red;
  logic               ang_flip;
  logic signed [33:0] dx, dy, atan_v;
  logic signed [33:0] xr_full, yr_full;
  logic signed [19:0] xr, yr;
  logic signed [20:0] sum_x, sum_y;
  logic signed [15:0] sat_x, sat_y;
  logic               slot_free;
  logic               last_now;

  assign cfg_ready_o   = 1'b1;
  assign in_ready_o    = (state_q == rpvg_pkg::ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign vertex_x_o    = vx_q;
  assign vertex_y_o    = vy_q;
  assign last_vertex_o = last_q;

  assign gain_prod = 46'(radius_q) * 46'(rpvg_pkg::CordicGain);

  // Restoring division of 2^16 by the count: shift in a one at the top bit only.
  assign div_shift = {rinc_q, (div_cnt_q == DW'(rpvg_pkg::DivTop))};
  assign div_ge    = (div_shift >= {1'b0, count_q});

  // Angle step: add quotient, carry one whenever the remainder wraps.
  assign rem_acc  = {1'b0, rem_q} + {1'b0, rinc_q};
  assign rem_wrap = (rem_acc >= {1'b0, count_q});

  // Fold the angle into -quarter..+quarter turn; flip the result sign then.
  always_comb begin
    ang_s    = $signed({ang_q[15], ang_q});
    ang_red  = 18'(ang_s);
    ang_flip = 1'b0;
    if (ang_s > 17'sd16384) begin
      ang_red  = 18'(ang_s) - 18'sd32768;
      ang_flip = 1'b1;
    end else if (ang_s < -17'sd16384) begin
      ang_red  = 18'(ang_s) + 18'sd32768;
      ang_flip = 1'b1;
    end
  end

  // Shared rotation step.
  assign dx     = y_q >>> step_q;
  assign dy     = x_q >>> step_q;
  assign atan_v = $signed({4'b0000, rpvg_pkg::AtanTab[AW'(step_q)]});

  // Round to Q12.4, apply the fold, add the centre and saturate.
  assign xr_full = x_q + 34'sd8192;
  assign yr_full = y_q + 34'sd8192;
  always_comb begin
    xr = xr_full[33:14];
    yr = yr_full[33:14];
    if (flip_q) begin
      xr = -xr;
      yr = -yr;
    end
    sum_x = 21'(xr) + 21'(cx_q);
    sum_y = 21'(yr) + 21'(cy_q);
    if (sum_x > 21'sd32767)       sat_x = 16'sh7fff;
    else if (sum_x < -21'sd32768) sat_x = -16'sh8000;
    else                          sat_x = sum_x[15:0];
    if (sum_y > 21'sd32767)       sat_y = 16'sh7fff;
    else if (sum_y < -21'sd32768) sat_y = -16'sh8000;
    else                          sat_y = sum_y[15:0];
  end

  assign slot_free = !out_valid_q || out_ready_i;
  assign last_now  = (idx_q == count_q - CW'(1));

  always_comb begin
    state_d      = state_q;
    side_count_d = side_count_q;
    radius_d     = radius_q;
    cx_d         = cx_q;
    cy_d         = cy_q;
    count_d      = count_q;
    idx_d        = idx_q;
    div_cnt_d    = div_cnt_q;
    quo_d        = quo_q;
    rinc_d       = rinc_q;
    rem_d        = rem_q;
    ang_d        = ang_q;
    x_d          = x_q;
    y_d          = y_q;
    z_d          = z_q;
    flip_d       = flip_q;
    step_d       = step_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    vx_d         = vx_q;
    vy_d         = vy_q;
    last_d       = last_q;

    if (cfg_valid_i) begin
      case (cfg_index_i)
        rpvg_pkg::CfgSideCount: side_count_d = cfg_data_i[7:0];
        rpvg_pkg::CfgRadius:    radius_d     = cfg_data_i;
        default: ;  // drop writes beyond the register list
      endcase
    end

    case (state_q)
      rpvg_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          // Latch the centre and the clamped side count.
          cx_d = center_x_i;
          cy_d = center_y_i;
          if (side_count_q < 8'(rpvg_pkg::MinSides)) begin
            count_d = CW'(rpvg_pkg::MinSides);
          end else if (side_count_q > 8'(MAX_SIDES)) begin
            count_d = CW'(MAX_SIDES);
          end else begin
            count_d = CW'(side_count_q);
          end
          idx_d     = '0;
          ang_d     = '0;
          quo_d     = '0;
          rinc_d    = '0;
          div_cnt_d = DW'(rpvg_pkg::DivTop);
          state_d   = rpvg_pkg::ST_DIV;
        end
      end
      rpvg_pkg::ST_DIV: begin
        quo_d  = {quo_q[14:0], div_ge};
        rinc_d = div_ge ? CW'(div_shift - {1'b0, count_q}) : CW'(div_shift);
        if (div_cnt_q == '0) begin
          // Angle 0 with half the count as rounding offset.
          rem_d   = count_q >> 1;
          state_d = rpvg_pkg::ST_SETUP;
        end else begin
          div_cnt_d = div_cnt_q - DW'(1);
        end
      end
      rpvg_pkg::ST_SETUP: begin
        x_d     = $signed({4'b0000, gain_q});
        y_d     = '0;
        z_d     = {ang_red[17:0], 16'b0};
        flip_d  = ang_flip;
        step_d  = '0;
        state_d = rpvg_pkg::ST_ITER;
      end
      rpvg_pkg::ST_ITER: begin
        if (!z_q[33]) begin
          x_d = x_q - dx;
          y_d = y_q + dy;
          z_d = z_q - atan_v;
        end else begin
          x_d = x_q + dx;
          y_d = y_q - dy;
          z_d = z_q + atan_v;
        end
        if (step_q == STW'(CORDIC_STEPS - 1)) begin
          state_d = rpvg_pkg::ST_EMIT;
        end else begin
          step_d = step_q + STW'(1);
        end
      end
      rpvg_pkg::ST_EMIT: begin
        // Hold until the output register is free.
        if (slot_free) begin
          out_valid_d = 1'b1;
          vx_d        = sat_x;
          vy_d        = sat_y;
          last_d      = last_now;
          if (last_now) begin
            idx_d   = '0;
            ang_d   = '0;
            state_d = rpvg_pkg::ST_IDLE;
          end else begin
            idx_d   = idx_q + CW'(1);
            rem_d   = rem_wrap ? CW'(rem_acc - {1'b0, count_q}) : CW'(rem_acc);
            ang_d   = ang_q + quo_q + 16'(rem_wrap);
            state_d = rpvg_pkg::ST_SETUP;
          end
        end
      end
      default: state_d = rpvg_pkg::ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= rpvg_pkg::ST_IDLE;
      side_count_q <= 8'd3;
      radius_q     <= '0;
      out_valid_q  <= 1'b0;
      idx_q        <= '0;
      ang_q        <= '0;
      count_q      <= CW'(rpvg_pkg::MinSides);
      rem_q        <= '0;
    end else begin
      state_q      <= state_d;
      side_count_q <= side_count_d;
      radius_q     <= radius_d;
      out_valid_q  <= out_valid_d;
      idx_q        <= idx_d;
      ang_q        <= ang_d;
      count_q      <= count_d;
      rem_q        <= rem_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    gain_q    <= gain_prod[45:16];
    cx_q      <= cx_d;
    cy_q      <= cy_d;
    div_cnt_q <= div_cnt_d;
    quo_q     <= quo_d;
    rinc_q    <= rinc_d;
    x_q       <= x_d;
    y_q       <= y_d;
    z_q       <= z_d;
    flip_q    <= flip_d;
    step_q    <= step_d;
    vx_q      <= vx_d;
    vy_q      <= vy_d;
    last_q    <= last_d;
  end

  // A non-final vertex in the output register means the polygon is still running.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_vertex_o |-> !in_ready_o)
    else $error("input taken while a polygon is unfinished");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != rpvg_pkg::ST_IDLE |->
      count_q >= CW'(rpvg_pkg::MinSides) && count_q <= CW'(MAX_SIDES))
    else $error("side count outside clamp range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != rpvg_pkg::ST_IDLE |-> idx_q < count_q)
    else $error("vertex index beyond side count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == rpvg_pkg::ST_EMIT && slot_free |=> out_valid_o)
    else $error("emitted vertex lost");

endmodule

FILE: tb/regular_polygon_vertex_generator_test.sv
// Self-checking testbench for regular_polygon_vertex_generator: drives polygon
// centers and register writes over valid/ready, predicts every vertex with a
// CORDIC model of its own and checks each output item. Depends on rpvg_pkg.
module regular_polygon_vertex_generator_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxSides    = rpvg_pkg::MaxSidesDef;
  localparam int CordicSteps = rpvg_pkg::CordicStepsDef;
  localparam int CycleLimit  = 1_000_000;
  localparam int TailCycles  = 40;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               last;
  } vertex_t;

  // Predict the vertices of each accepted center and hold them in order.
  class vertex_scoreboard;
    logic [7:0]  side_count;
    logic [15:0] radius;
    vertex_t     expected_vertices[$];

    function new();
      side_count = 8'd3;
      radius     = 16'd0;
    endfunction

    function void write_reg(logic [rpvg_pkg::CfgIdxW-1:0] idx, logic [15:0] data);
      case (idx)
        rpvg_pkg::CfgSideCount: side_count = data[7:0];
        rpvg_pkg::CfgRadius:    radius = data;
        default: ;
      endcase
    endfunction

    function logic signed [15:0] sat16(longint v);
      if (v > 32767) return 16'sd32767;
      if (v < -32768) return -16'sd32768;
      return 16'(v);
    endfunction

    // radius * (cos, sin) of a 16-bit binary angle, rounded to Q12.4
    function void rotate(logic [15:0] angle, logic [15:0] r,
                         output longint cos_part, output longint sin_part);
      longint x, y, z, dx, dy;
      bit     flip;
      z = longint'(angle) << 16;
      if (z >= 64'sd2147483648) z = z - 64'sd4294967296;
      flip = 1'b0;
      if (z > 64'sd1073741824) begin
        z    = z - 64'sd2147483648;
        flip = 1'b1;
      end else if (z < -64'sd1073741824) begin
        z    = z + 64'sd2147483648;
        flip = 1'b1;
      end
      x = (longint'(r) * longint'(rpvg_pkg::CordicGain)) >>> 16;
      y = 0;
      for (int i = 0; i < CordicSteps && i < rpvg_pkg::AtanDepth; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x = x - dx;
          y = y + dy;
          z = z - longint'(rpvg_pkg::AtanTab[i]);
        end else begin
          x = x + dx;
          y = y - dy;
          z = z + longint'(rpvg_pkg::AtanTab[i]);
        end
      end
      x = (x + 8192) >>> 14;
      y = (y + 8192) >>> 14;
      cos_part = flip ? -x : x;
      sin_part = flip ? -y : y;
    endfunction

    function void note_center(logic signed [15:0] cx, logic signed [15:0] cy);
      int unsigned count;
      logic [15:0] angle;
      longint      dx, dy;
      vertex_t     v;
      count = side_count;
      if (count < rpvg_pkg::MinSides) count = rpvg_pkg::MinSides;
      if (count > MaxSides) count = MaxSides;
      for (int unsigned k = 0; k < count; k++) begin
        angle  = 16'(((longint'(k) << 16) + longint'(count / 2)) / longint'(count));
        rotate(angle, radius, dx, dy);
        v.x    = sat16(longint'(cx) + dx);
        v.y    = sat16(longint'(cy) + dy);
        v.last = (k + 1 == count);
        expected_vertices.insert(expected_vertices.size(), v);
      end
    endfunction

    // Return an empty string on a match, else a description of the mismatch.
    function string check_vertex(logic signed [15:0] x, logic signed [15:0] y,
                                 logic last);
      vertex_t exp_v;
      string   msg;
      if (expected_vertices.size() == 0)
        return $sformatf("unexpected vertex x=%0d y=%0d last=%0b", x, y, last);
      exp_v = expected_vertices.pop_front();
      msg = "";
      if (x !== exp_v.x) msg = {msg, $sformatf(" x=%0d exp %0d", x, exp_v.x)};
      if (y !== exp_v.y) msg = {msg, $sformatf(" y=%0d exp %0d", y, exp_v.y)};
      if (last !== exp_v.last)
        msg = {msg, $sformatf(" last=%0b exp %0b", last, exp_v.last)};
      if (msg.len() != 0) msg = {"vertex mismatch:", msg};
      return msg;
    endfunction

    function int pending();
      return expected_vertices.size();
    endfunction
  endclass

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [rpvg_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [15:0]                  cfg_data = '0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic signed [15:0]           center_x = '0;
  logic signed [15:0]           center_y = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic signed [15:0]           vertex_x;
  logic signed [15:0]           vertex_y;
  logic                         last_vertex;

  vertex_scoreboard sb = new();
  int    error_count = 0;
  int    cycle_count = 0;
  int    sender_idle_pct = 0;
  int    receiver_idle_pct = 0;
  int    small_sides[6] = '{1, 2, 5, 6, 7, 8};
  string check_msg;

  regular_polygon_vertex_generator #(
    .MAX_SIDES   (MaxSides),
    .CORDIC_STEPS(CordicSteps)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .center_x_i   (center_x),
    .center_y_i   (center_y),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .vertex_x_o   (vertex_x),
    .vertex_y_o   (vertex_y),
    .last_vertex_o(last_vertex)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Abort the run if the block hangs.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("TIMEOUT after %0d cycles, %0d vertices outstanding", cycle_count,
               sb.pending());
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic report_mismatch(string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Throttle the output side; a zero percentage keeps ready high.
  always @(posedge clk_i) begin
    out_ready <= ($urandom_range(99) >= receiver_idle_pct);
  end

  // Sample all handshakes at the edge, before this edge's updates land.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) sb.note_center(center_x, center_y);
      if (out_valid && out_ready) begin
        check_msg = sb.check_vertex(vertex_x, vertex_y, last_vertex);
        if (check_msg.len() != 0) report_mismatch(check_msg);
      end
    end
  end

  // Present one center and hold it until accepted. Valid stays high on return
  // so a following item can go out back to back.
  task automatic send_center(logic signed [15:0] cx, logic signed [15:0] cy);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    center_x <= cx;
    center_y <= cy;
    do @(posedge clk_i); while (!in_ready);
  endtask

  // Drop valid and wait until every predicted vertex has come out, then let
  // the block settle back to idle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [rpvg_pkg::CfgIdxW-1:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic signed [15:0] rand_coord();
    case ($urandom_range(7))
      0: return 16'sh7FFF;
      1: return -16'sh8000;
      2: return 16'($urandom_range(0, 255)) - 16'sd128;
      default: return 16'($urandom);
    endcase
  endfunction

  // Keep most polygons small; only a few reach the largest count.
  function automatic logic [15:0] rand_side_data();
    logic [7:0] sides;
    case ($urandom_range(9))
      0: sides = 8'($urandom);
      1, 2: sides = 8'($urandom_range(9, 16));
      default: sides = 8'($urandom_range(0, 8));
    endcase
    return {8'($urandom), sides};
  endfunction

  function automatic logic [15:0] rand_radius();
    case ($urandom_range(5))
      0: return 16'($urandom_range(0, 255));
      1: return 16'($urandom_range(0, 16'h3FFF));
      2: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Run segments of random centers, each under a fresh configuration written
  // while the block is idle.
  task automatic run_random_phase(int sender_pct, int receiver_pct, int n_items);
    int sent;
    int seg_len;
    sender_idle_pct   = sender_pct;
    receiver_idle_pct = receiver_pct;
    sent = 0;
    while (sent < n_items) begin
      drain();
      if ($urandom_range(3) == 0)
        write_cfg(rpvg_pkg::CfgIdxW'(2 + $urandom_range(1)), 16'($urandom));
      write_cfg(rpvg_pkg::CfgSideCount, rand_side_data());
      write_cfg(rpvg_pkg::CfgRadius, rand_radius());
      seg_len = $urandom_range(4, 12);
      for (int i = 0; i < seg_len && sent < n_items; i++) begin
        send_center(rand_coord(), rand_coord());
        sent++;
        // Hold off now and then until the block has emptied.
        if ($urandom_range(39) == 0) drain();
      end
    end
  endtask

  initial begin
    sender_idle_pct   = 23;
    receiver_idle_pct = 63;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset configuration: triangle of zero radius, every vertex on the center.
    send_center(16'sd0, 16'sd0);
    send_center(16'sh7FFF, -16'sh8000);
    drain();

    // Count far above the maximum, full radius: clamp to the maximum count and
    // saturate at the coordinate extremes.
    write_cfg(rpvg_pkg::CfgSideCount, 16'hFFFF);
    write_cfg(rpvg_pkg::CfgRadius, 16'hFFFF);
    send_center(16'sd0, 16'sd0);
    send_center(16'sh7FFF, 16'sh7FFF);
    send_center(-16'sh8000, -16'sh8000);
    drain();

    // Count of zero falls back to the minimum.
    write_cfg(rpvg_pkg::CfgSideCount, 16'hFF00);
    write_cfg(rpvg_pkg::CfgRadius, 16'h0010);
    send_center(16'sd100, -16'sd100);
    drain();

    // Writes beyond the register list must leave the configuration alone.
    write_cfg(rpvg_pkg::CfgIdxW'(2), 16'h0005);
    write_cfg(rpvg_pkg::CfgIdxW'(3), 16'hFFFF);
    send_center(16'sd0, 16'sd0);
    drain();

    write_cfg(rpvg_pkg::CfgSideCount, 16'd16);
    write_cfg(rpvg_pkg::CfgRadius, 16'h4000);
    send_center(-16'sh8000, 16'sh7FFF);
    send_center(16'sd0, 16'sd0);
    drain();

    write_cfg(rpvg_pkg::CfgSideCount, 16'd17);
    write_cfg(rpvg_pkg::CfgRadius, 16'h1234);
    send_center(16'sh1234, -16'sh1234);
    drain();

    write_cfg(rpvg_pkg::CfgSideCount, 16'd4);
    write_cfg(rpvg_pkg::CfgRadius, 16'h8000);
    send_center(16'sd0, 16'sd0);
    send_center(16'sh7FFF, 16'sd0);
    drain();

    foreach (small_sides[i]) begin
      write_cfg(rpvg_pkg::CfgSideCount, 16'(small_sides[i]));
      write_cfg(rpvg_pkg::CfgRadius, 16'($urandom));
      send_center(rand_coord(), rand_coord());
      drain();
    end

    run_random_phase(23, 63, 66);
    run_random_phase(63, 23, 66);
    run_random_phase(0, 0, 66);

    drain();
    repeat (TailCycles) @(posedge clk_i);
    if (sb.pending() != 0)
      report_mismatch($sformatf("%0d vertices never arrived", sb.pending()));
    if (error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
